// ===== sv/utv_pkg.sv =====
`timescale 1ns / 1ps

package utv_pkg;

  localparam int LENGTH_WIDTH = 16;
  localparam int CAP_WIDTH    = 16;
  localparam int SCALAR_WIDTH = 21;
  localparam int CMP_WIDTH    = (LENGTH_WIDTH > CAP_WIDTH) ? LENGTH_WIDTH : CAP_WIDTH;

  localparam logic [CAP_WIDTH-1:0] CAP_RESET = CAP_WIDTH'(256);

  typedef logic [SCALAR_WIDTH-1:0] scalar_t;
  typedef logic [LENGTH_WIDTH-1:0] length_t;
  typedef logic [CAP_WIDTH-1:0]    cap_t;

  // minimum scalar a sequence may encode, by lead byte class
  typedef enum logic [1:0] {
    MIN_ASCII = 2'd0,
    MIN_2BYTE = 2'd1,
    MIN_3BYTE = 2'd2,
    MIN_4BYTE = 2'd3
  } min_class_t;

  typedef struct packed {
    logic [1:0] pending;
    scalar_t    accum;
    min_class_t min_class;
    logic       error;
  } dec_state_t;

  localparam dec_state_t DEC_STATE_CLEAR = '{
    pending:   2'd0,
    accum:     '0,
    min_class: MIN_ASCII,
    error:     1'b0
  };

  function automatic scalar_t min_scalar(min_class_t cls);
    scalar_t m;
    case (cls)
      MIN_ASCII: m = SCALAR_WIDTH'(32'h0);
      MIN_2BYTE: m = SCALAR_WIDTH'(32'h80);
      MIN_3BYTE: m = SCALAR_WIDTH'(32'h800);
      MIN_4BYTE: m = SCALAR_WIDTH'(32'h10000);
      default:   m = '0;
    endcase
    return m;
  endfunction

  function automatic logic scalar_ok(scalar_t s, min_class_t cls);
    logic ok;
    ok = 1'b1;
    if (s < min_scalar(cls)) ok = 1'b0;
    if (s > SCALAR_WIDTH'(32'h10FFFF)) ok = 1'b0;
    if (s >= SCALAR_WIDTH'(32'hD800) && s <= SCALAR_WIDTH'(32'hDFFF)) ok = 1'b0;
    if (s < SCALAR_WIDTH'(32'h20)) ok = 1'b0;
    if (s >= SCALAR_WIDTH'(32'h7F) && s <= SCALAR_WIDTH'(32'h9F)) ok = 1'b0;
    if (s == SCALAR_WIDTH'(32'h2028) || s == SCALAR_WIDTH'(32'h2029)) ok = 1'b0;
    return ok;
  endfunction

endpackage

// ===== sv/utv_decode.sv =====
`timescale 1ns / 1ps

module utv_decode (
  input  utv_pkg::dec_state_t cur,
  input  logic [7:0]          data,
  output utv_pkg::dec_state_t nxt
);
  import utv_pkg::*;

  scalar_t shifted;
  logic [1:0] pending_dec;

  assign shifted     = {cur.accum[SCALAR_WIDTH-7:0], data[5:0]};
  assign pending_dec = cur.pending - 2'd1;

  always_comb begin
    nxt = cur;
    if (!cur.error) begin
      if (cur.pending == 2'd0) begin
        if (data < 8'h80) begin
          if (!scalar_ok(SCALAR_WIDTH'(data), MIN_ASCII)) nxt.error = 1'b1;
        end else if (data >= 8'hC2 && data <= 8'hDF) begin
          nxt.accum     = SCALAR_WIDTH'(data[4:0]);
          nxt.min_class = MIN_2BYTE;
          nxt.pending   = 2'd1;
        end else if (data >= 8'hE0 && data <= 8'hEF) begin
          nxt.accum     = SCALAR_WIDTH'(data[3:0]);
          nxt.min_class = MIN_3BYTE;
          nxt.pending   = 2'd2;
        end else if (data >= 8'hF0 && data <= 8'hF4) begin
          nxt.accum     = SCALAR_WIDTH'(data[2:0]);
          nxt.min_class = MIN_4BYTE;
          nxt.pending   = 2'd3;
        end else begin
          nxt.error = 1'b1;
        end
      end else if (data[7:6] != 2'b10) begin
        // bad continuation drops the sequence
        nxt = DEC_STATE_CLEAR;
        nxt.error = 1'b1;
      end else if (pending_dec == 2'd0) begin
        nxt = DEC_STATE_CLEAR;
        nxt.error = !scalar_ok(shifted, cur.min_class);
      end else begin
        nxt.accum   = shifted;
        nxt.pending = pending_dec;
      end
    end
  end

endmodule

// ===== sv/utf8_text_validator.sv =====
`timescale 1ns / 1ps

// Streaming UTF-8 checker: takes one text byte per cycle unless in_stall is
// high, and gives one valid_res per terminator (1 = non-empty, well-formed,
// permitted scalars only, not cut mid-sequence, length below capacity). A
// request goes into an input register and is decoded from there, so
// throughput is one request per clock while in_stall stays low; the verdict
// is registered in the output register when the terminator leaves the input
// register. The output register parts the two sides: bytes keep flowing while
// a verdict waits, and only a second terminator waits for the output to drain.
// capacity may be written only while the block is idle.
module utf8_text_validator (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_write,
  input  utv_pkg::cap_t        cfg_data,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [7:0]           text_byte,
  input  logic                 end_of_text,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic                 valid_res
);
  import utv_pkg::*;

  cap_t       capacity;
  dec_state_t dec_state;
  dec_state_t dec_state_next;
  length_t    byte_count;

  logic       stage_valid;
  logic [7:0] stage_byte;
  logic       stage_end;

  logic out_free;
  logic stage_go;
  logic verdict;
  logic [CMP_WIDTH-1:0] count_ext;
  logic [CMP_WIDTH-1:0] cap_ext;

  assign out_free = !out_valid || !out_stall;
  assign stage_go = stage_valid && (!stage_end || out_free);
  assign in_stall = stage_valid && !stage_go;

  utv_decode u_decode (
    .cur  (dec_state),
    .data (stage_byte),
    .nxt  (dec_state_next)
  );

  assign count_ext = CMP_WIDTH'(byte_count);
  assign cap_ext   = CMP_WIDTH'(capacity);
  assign verdict   = !dec_state.error && dec_state.pending == 2'd0 &&
                     byte_count != '0 && byte_count != '1 && count_ext < cap_ext;

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= CAP_RESET;
    end else if (cfg_write) begin
      capacity <= cfg_data;
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (!in_stall) begin
      stage_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      stage_byte <= text_byte;
      stage_end  <= end_of_text;
    end
  end

  // text state
  always_ff @(posedge clk) begin
    if (rst) begin
      dec_state  <= DEC_STATE_CLEAR;
      byte_count <= '0;
    end else if (stage_go) begin
      if (stage_end) begin
        dec_state  <= DEC_STATE_CLEAR;
        byte_count <= '0;
      end else begin
        dec_state <= dec_state_next;
        if (byte_count != '1) byte_count <= byte_count + LENGTH_WIDTH'(1);
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= stage_go && stage_end;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && stage_go && stage_end) valid_res <= verdict;
  end

endmodule

// ===== test/utf8_verdict_checker.sv =====
`timescale 1ns / 1ps

module utf8_verdict_checker (
  input  logic          clk,
  input  logic          rst,
  input  logic          cfg_write,
  input  utv_pkg::cap_t cfg_data,
  input  logic          in_valid,
  input  logic          in_stall,
  input  logic [7:0]    text_byte,
  input  logic          end_of_text,
  input  logic          out_valid,
  input  logic          out_stall,
  input  logic          valid_res,
  output int            fail_count,
  output int            verdicts_due
);
  import utv_pkg::*;

  localparam logic [7:0] LEAD2_LO = 8'hC2;
  localparam logic [7:0] LEAD2_HI = 8'hDF;
  localparam logic [7:0] LEAD3_LO = 8'hE0;
  localparam logic [7:0] LEAD3_HI = 8'hEF;
  localparam logic [7:0] LEAD4_LO = 8'hF0;
  localparam logic [7:0] LEAD4_HI = 8'hF4;

  // decoder copy kept by the checker
  logic [1:0] need;
  scalar_t    acc;
  min_class_t cls;
  logic       bad_text;
  length_t    seen_count;
  cap_t       cap;

  logic verdict_q[$];

  function automatic logic allowed(scalar_t s, min_class_t c);
    scalar_t floor_v;
    logic    forbidden;
    case (c)
      MIN_2BYTE: floor_v = 21'h80;
      MIN_3BYTE: floor_v = 21'h800;
      MIN_4BYTE: floor_v = 21'h10000;
      default:   floor_v = 21'h0;
    endcase
    forbidden = (s < floor_v) || (s > 21'h10FFFF) ||
                (s >= 21'hD800 && s <= 21'hDFFF) || (s < 21'h20) ||
                (s >= 21'h7F && s <= 21'h9F) || (s == 21'h2028) || (s == 21'h2029);
    return !forbidden;
  endfunction

  function automatic void clear_text();
    need       = 2'd0;
    acc        = '0;
    cls        = MIN_ASCII;
    bad_text   = 1'b0;
    seen_count = '0;
  endfunction

  function automatic void absorb_byte(logic [7:0] b);
    if (seen_count != '1) seen_count = seen_count + LENGTH_WIDTH'(1);
    if (bad_text) return;
    if (need == 2'd0) begin
      if (b < 8'h80) begin
        if (!allowed({13'd0, b}, MIN_ASCII)) bad_text = 1'b1;
      end else if (b >= LEAD2_LO && b <= LEAD2_HI) begin
        acc  = {16'd0, b[4:0]};
        cls  = MIN_2BYTE;
        need = 2'd1;
      end else if (b >= LEAD3_LO && b <= LEAD3_HI) begin
        acc  = {17'd0, b[3:0]};
        cls  = MIN_3BYTE;
        need = 2'd2;
      end else if (b >= LEAD4_LO && b <= LEAD4_HI) begin
        acc  = {18'd0, b[2:0]};
        cls  = MIN_4BYTE;
        need = 2'd3;
      end else begin
        bad_text = 1'b1;
      end
    end else if (b[7:6] != 2'b10) begin
      // broken sequence is dropped
      bad_text = 1'b1;
      need     = 2'd0;
      acc      = '0;
      cls      = MIN_ASCII;
    end else begin
      acc  = {acc[14:0], b[5:0]};
      need = need - 2'd1;
      if (need == 2'd0) begin
        if (!allowed(acc, cls)) bad_text = 1'b1;
        acc = '0;
        cls = MIN_ASCII;
      end
    end
  endfunction

  function automatic void close_text();
    logic ok;
    ok = !bad_text && need == 2'd0 && seen_count != '0 && seen_count != '1 &&
         seen_count < cap;
    verdict_q.push_back(ok);
    clear_text();
  endfunction

  initial begin
    fail_count   = 0;
    verdicts_due = 0;
    cap          = CAP_RESET;
    clear_text();
  end

  always @(posedge clk) begin
    logic want;
    if (rst) begin
      cap = CAP_RESET;
      clear_text();
      verdict_q.delete();
    end else begin
      if (cfg_write) cap = cfg_data;
      if (in_valid && !in_stall) begin
        if (end_of_text) close_text();
        else absorb_byte(text_byte);
      end
      if (out_valid && !out_stall) begin
        if (verdict_q.size() == 0) begin
          $error("valid_res: expected none, actual %0b", valid_res);
          fail_count = fail_count + 1;
        end else begin
          want = verdict_q.pop_front();
          if (want !== valid_res) begin
            $error("valid_res: expected %0b, actual %0b", want, valid_res);
            fail_count = fail_count + 1;
          end
        end
      end
    end
    verdicts_due = verdict_q.size();
  end

endmodule

// ===== test/utf8_text_validator_tb.sv =====
`timescale 1ns / 1ps

module utf8_text_validator_tb;
  import utv_pkg::*;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       cfg_write = 1'b0;
  cap_t       cfg_data = '0;
  logic       in_valid = 1'b0;
  logic [7:0] text_byte = 8'h00;
  logic       end_of_text = 1'b0;
  logic       out_stall = 1'b0;
  wire        in_stall;
  wire        out_valid;
  wire        valid_res;

  int fail_count;
  int verdicts_due;
  int items_sent = 0;

  bit idle_on = 1'b1;
  bit rx_quiet = 1'b0;
  int rx_hold = 0;

  always #5 clk = ~clk;

  utf8_text_validator DUT (
    .clk        (clk),
    .rst        (rst),
    .cfg_write  (cfg_write),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .text_byte  (text_byte),
    .end_of_text(end_of_text),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .valid_res  (valid_res)
  );

  utf8_verdict_checker CHK (
    .clk         (clk),
    .rst         (rst),
    .cfg_write   (cfg_write),
    .cfg_data    (cfg_data),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .text_byte   (text_byte),
    .end_of_text (end_of_text),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .valid_res   (valid_res),
    .fail_count  (fail_count),
    .verdicts_due(verdicts_due)
  );

  // receiver: random stalls, a quiet mode, and a counted long hold-off
  initial begin
    forever begin
      @(posedge clk);
      if (rx_hold > 0) begin
        out_stall <= 1'b1;
        rx_hold = rx_hold - 1;
      end else if (rx_quiet) begin
        out_stall <= 1'b0;
      end else begin
        out_stall <= ($urandom_range(0, 99) < 29);
      end
    end
  end

  task automatic send_item(input logic [7:0] b, input logic e);
    while (idle_on && $urandom_range(0, 99) < 29) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid    <= 1'b1;
    text_byte   <= b;
    end_of_text <= e;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    items_sent = items_sent + 1;
  endtask

  task automatic send_text(input logic [7:0] q[$]);
    foreach (q[i]) send_item(q[i], 1'b0);
    // byte value on the terminator does not matter
    send_item(8'($urandom), 1'b1);
  endtask

  // wait for every verdict, let the pipeline settle, then write capacity
  task automatic write_capacity(input cap_t v);
    in_valid <= 1'b0;
    wait (verdicts_due == 0);
    repeat (4) @(posedge clk);
    cfg_write <= 1'b1;
    cfg_data  <= v;
    @(posedge clk);
    cfg_write <= 1'b0;
  endtask

  task automatic put_scalar(ref logic [7:0] q[$], input scalar_t s, input int n);
    case (n)
      1: q.push_back({1'b0, s[6:0]});
      2: begin
        q.push_back({3'b110, s[10:6]});
        q.push_back({2'b10, s[5:0]});
      end
      3: begin
        q.push_back({4'b1110, s[15:12]});
        q.push_back({2'b10, s[11:6]});
        q.push_back({2'b10, s[5:0]});
      end
      default: begin
        q.push_back({5'b11110, s[20:18]});
        q.push_back({2'b10, s[17:12]});
        q.push_back({2'b10, s[11:6]});
        q.push_back({2'b10, s[5:0]});
      end
    endcase
  endtask

  task automatic push_char(ref logic [7:0] q[$], input bit clean);
    int      r;
    int      n;
    scalar_t s;
    if (clean) begin
      r = $urandom_range(0, 99);
      if (r < 40) begin
        s = 21'($urandom_range(21'h20, 21'h7E));
        n = 1;
      end else if (r < 65) begin
        s = 21'($urandom_range(21'hA0, 21'h7FF));
        n = 2;
      end else if (r < 85) begin
        s = 21'($urandom_range(21'h800, 21'hFFFF));
        if (s >= 21'hD800 && s <= 21'hDFFF) s = s - 21'h1000;
        if (s == 21'h2028 || s == 21'h2029) s = 21'h20AC;
        n = 3;
      end else begin
        s = 21'($urandom_range(21'h10000, 21'h10FFFF));
        n = 4;
      end
      put_scalar(q, s, n);
    end else begin
      r = $urandom_range(0, 6);
      case (r)
        0: q.push_back(8'($urandom));
        1: begin
          s = ($urandom_range(0, 3) == 0) ? 21'h7F : 21'($urandom_range(0, 31));
          put_scalar(q, s, 1);
        end
        2: begin
          // overlong form
          n = $urandom_range(2, 4);
          s = (n == 2) ? 21'($urandom_range(0, 8'h7F)) : 21'($urandom_range(0, 12'h7FF));
          put_scalar(q, s, n);
        end
        3: put_scalar(q, 21'($urandom_range(21'hD800, 21'hDFFF)), 3);
        4: put_scalar(q, 21'h2028 + 21'($urandom_range(0, 1)), 3);
        5: put_scalar(q, 21'($urandom_range(21'h110000, 21'h1FFFFF)), 4);
        default: put_scalar(q, 21'($urandom_range(21'h80, 21'h9F)), 2);
      endcase
    end
  endtask

  task automatic random_text(input int max_chars);
    logic [7:0] q[$];
    int         nchars;
    bit         clean;
    nchars = $urandom_range(0, max_chars);
    clean  = ($urandom_range(0, 99) < 70);
    for (int k = 0; k < nchars; k++) push_char(q, clean || $urandom_range(0, 3) != 0);
    // cut off mid-sequence now and then
    if (q.size() > 0 && $urandom_range(0, 9) == 0) void'(q.pop_back());
    send_text(q);
  endtask

  task automatic random_phase(input int budget, input int max_chars);
    int start;
    start = items_sent;
    while (items_sent - start < budget) random_text(max_chars);
  endtask

  initial begin
    #20_000_000;
    $display("Regression FAIL");
    $finish;
  end

  initial begin
    logic [7:0] q[$];
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // empty text
    q.delete();
    send_text(q);
    q = '{8'h20};
    send_text(q);
    // nul as a data byte
    q = '{8'h00};
    send_text(q);
    q = '{8'h7F};
    send_text(q);
    // c1 control in two bytes
    q = '{8'hC2, 8'h80};
    send_text(q);
    // highest scalar
    q = '{8'hF4, 8'h8F, 8'hBF, 8'hBF};
    send_text(q);
    // truncated sequence
    q = '{8'hE2, 8'h82};
    send_text(q);
    // bad continuation
    q = '{8'hE2, 8'h41};
    send_text(q);
    q = '{8'hFF};
    send_text(q);

    write_capacity(16'd0);
    random_phase(200, 4);
    write_capacity(16'd1);
    random_phase(150, 2);
    write_capacity(16'd2);
    random_phase(150, 2);

    write_capacity(16'hFFFF);
    random_phase(200, 8);

    // long receiver hold-off while short texts keep coming
    write_capacity(16'($urandom_range(3, 24)));
    rx_hold = 300;
    repeat (12) random_text(2);
    random_phase(250, 6);

    write_capacity(16'($urandom_range(3, 24)));
    idle_on  = 1'b0;
    rx_quiet = 1'b1;
    random_phase(300, 6);
    idle_on  = 1'b1;
    rx_quiet = 1'b0;

    write_capacity(16'($urandom_range(3, 24)));
    random_phase(300, 6);
    write_capacity(16'd256);
    random_phase(350, 8);

    in_valid <= 1'b0;
    wait (verdicts_due == 0);
    repeat (10) @(posedge clk);
    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
sv/utv_pkg.sv
sv/utv_decode.sv
sv/utf8_text_validator.sv
test/utf8_verdict_checker.sv
test/utf8_text_validator_tb.sv
